FILE: src/rbm_pkg.sv
// Shared types and constants for the reachability bitmap matrix.
package rbm_pkg;

    localparam int ROW_W      = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int KIND_W     = 3;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 72;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_BEGIN  = 3'd0;
    localparam kind_t KIND_ADD    = 3'd1;
    localparam kind_t KIND_QUERY  = 3'd2;
    localparam kind_t KIND_MEMBER = 3'd3;
    localparam kind_t KIND_APPLY  = 3'd4;

    // Outcome of one row operation, handed from the row ALU to the top level.
    typedef struct packed {
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic             connected;
        logic [ROW_W-1:0] row;
        logic             err;
        logic             fuse;
    } alu_res_t;

endpackage

FILE: src/rbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rbm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/rbm_row_alu.sv
// Row operation for every kind except the fusion walk.
module rbm_row_alu (
    input  rbm_pkg::kind_t                 kind,
    input  logic [rbm_pkg::IDX_W-1:0]      node_index,
    input  logic [rbm_pkg::IDX_W-1:0]      other_index,
    input  logic                           self_loop,
    input  logic                           n_ok,
    input  logic                           o_ok,
    input  logic [rbm_pkg::ROW_W-1:0]      row_n,
    input  logic [rbm_pkg::ROW_W-1:0]      row_o,
    output rbm_pkg::alu_res_t              res
);

    logic [rbm_pkg::ROW_W-1:0] own_bit;
    logic [rbm_pkg::ROW_W-1:0] begin_row;

    assign own_bit   = rbm_pkg::ROW_W'(1) << node_index;
    assign begin_row = (self_loop ? row_n : '0) | own_bit;

    always_comb
    begin
        res = '0;
        unique case (kind)
            rbm_pkg::KIND_BEGIN:
            begin
                if (!n_ok)
                begin
                    res.err = 1'b1;
                end
                else
                begin
                    res.wr_en  = 1'b1;
                    res.wr_row = begin_row;
                    res.row    = begin_row;
                end
            end
            rbm_pkg::KIND_ADD:
            begin
                if (!n_ok || !o_ok)
                begin
                    res.err = 1'b1;
                end
                else if (other_index != node_index)
                begin
                    res.wr_en  = 1'b1;
                    res.wr_row = row_n | row_o;
                    res.row    = row_n | row_o;
                end
                else
                begin
                    // self edge: keep the row as it is
                    res.row = row_n;
                end
            end
            rbm_pkg::KIND_QUERY:
            begin
                if (!n_ok || !o_ok)
                begin
                    res.err = 1'b1;
                end
                else
                begin
                    res.row       = row_n;
                    res.connected = row_n[other_index];
                end
            end
            rbm_pkg::KIND_MEMBER:
            begin
                if (!n_ok)
                begin
                    res.err = 1'b1;
                end
                else
                begin
                    res.fuse = 1'b1;
                    res.row  = row_n;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

FILE: src/reachability_bitmap_matrix.sv
// Top level of the reachability bitmap matrix: control, fusion walk and output stage.
//
//  channel | direction | handshake             | content
//  --------+-----------+-----------------------+--------------------------------------
//  s_*     | in        | s_tvalid / s_tready   | tdata: node_index, other_index,
//          |           |                       |        self_loop; tuser: kind
//  m_*     | out       | m_tvalid / m_tready   | tdata: connected, row_bits; tuser:
//          |           |                       |        index_error
//  cfg_*   | in        | cfg_valid / cfg_ready | node_count (always ready)
//
// For an item, the accept cycle reads its rows from the registered-read RAM, and the
// modify cycle then writes the row back and loads the output beat. fusion_apply walks
// rows 0 to count-1, count being node_count saturated at MAX_NODES, one RAM read per
// row in a two-stage read / update pipeline; it then leaves the walk and replies.
// Reset clears one valid flag per row at once; a row never written reads as zero,
// so no clearing pass is needed. A stalled output beat is held in its register while
// the next beat is accepted; the modify cycle then waits until the output frees up.
module reachability_bitmap_matrix #(
    parameter int MAX_NODES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rbm_pkg::CNT_W-1:0]          cfg_data,
    // input beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rbm_pkg::IN_DATA_W-1:0]      s_tdata,   // [5:0] node_index, [11:6] other_index,
                                                          // [12] self_loop, [15:13] zero
    input  logic [rbm_pkg::KIND_W-1:0]         s_tuser,   // [2:0] kind
    // output beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rbm_pkg::OUT_DATA_W-1:0]     m_tdata,   // [0] connected, [64:1] row_bits,
                                                          // [71:65] zero
    output logic                               m_tuser    // [0] index_error
);

    localparam int AW    = $clog2(MAX_NODES);
    localparam int ROW_W = rbm_pkg::ROW_W;
    localparam int IDX_W = rbm_pkg::IDX_W;
    localparam int CNT_W = rbm_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_FIN
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       node_count_reg, node_count_next;
    logic [MAX_NODES-1:0]   row_valid_reg, row_valid_next;
    logic [ROW_W-1:0]       union_reg, union_next;
    logic [ROW_W-1:0]       mask_reg, mask_next;
    logic [CNT_W-1:0]       walk_rd_reg, walk_rd_next;
    logic                   pipe_v_reg, pipe_v_next;
    logic                   out_valid_reg, out_valid_next;

    // payload registers
    rbm_pkg::kind_t         kind_reg, kind_next;
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       o_reg, o_next;
    logic                   self_reg, self_next;
    logic [IDX_W-1:0]       pipe_idx_reg, pipe_idx_next;
    logic [ROW_W-1:0]       cap_row_reg, cap_row_next;
    logic                   out_conn_reg, out_conn_next;
    logic [ROW_W-1:0]       out_row_reg, out_row_next;
    logic                   out_err_reg, out_err_next;

    // RAM ports; the two copies always hold the same rows
    logic                   rd_en_a, rd_en_b;
    logic [AW-1:0]          rd_addr_a, rd_addr_b;
    logic [ROW_W-1:0]       rd_data_a, rd_data_b;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [ROW_W-1:0]       wr_data;

    logic [CNT_W-1:0]       cnt;
    logic                   n_ok, o_ok;
    logic                   valid_n, valid_o, valid_p;
    logic [ROW_W-1:0]       row_n, row_o, row_p, row_p_new;
    logic                   slot_free;
    rbm_pkg::alu_res_t      alu_res;

    // effective node count saturates at the table depth
    assign cnt  = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_reg;
    assign n_ok = {1'b0, n_reg} < cnt;
    assign o_ok = {1'b0, o_reg} < cnt;

    // rows never written since reset read as zero
    assign valid_n = (int'(n_reg) < MAX_NODES) && row_valid_reg[n_reg[AW-1:0]];
    assign valid_o = (int'(o_reg) < MAX_NODES) && row_valid_reg[o_reg[AW-1:0]];
    assign valid_p = (int'(pipe_idx_reg) < MAX_NODES) && row_valid_reg[pipe_idx_reg[AW-1:0]];
    assign row_n   = valid_n ? rd_data_a : '0;
    assign row_o   = valid_o ? rd_data_b : '0;
    assign row_p   = valid_p ? rd_data_a : '0;

    // walk stage: fold the union into any row holding a fused node's bit
    assign row_p_new = ((row_p & mask_reg) != '0) ? (row_p | union_reg) : row_p;

    assign slot_free = !out_valid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(rbm_pkg::OUT_DATA_W - ROW_W - 1)'(0), out_row_reg, out_conn_reg};
    assign m_tuser   = out_err_reg;

    rbm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_NODES),
        .ADDR_W(AW)
    ) u_ram_a (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en_a),
        .rd_addr(rd_addr_a),
        .rd_data(rd_data_a)
    );

    rbm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_NODES),
        .ADDR_W(AW)
    ) u_ram_b (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en_b),
        .rd_addr(rd_addr_b),
        .rd_data(rd_data_b)
    );

    rbm_row_alu u_alu (
        .kind       (kind_reg),
        .node_index (n_reg),
        .other_index(o_reg),
        .self_loop  (self_reg),
        .n_ok       (n_ok),
        .o_ok       (o_ok),
        .row_n      (row_n),
        .row_o      (row_o),
        .res        (alu_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        row_valid_next  = row_valid_reg;
        union_next      = union_reg;
        mask_next       = mask_reg;
        walk_rd_next    = walk_rd_reg;
        pipe_v_next     = pipe_v_reg;
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        n_next          = n_reg;
        o_next          = o_reg;
        self_next       = self_reg;
        pipe_idx_next   = pipe_idx_reg;
        cap_row_next    = cap_row_reg;
        out_conn_next   = out_conn_reg;
        out_row_next    = out_row_reg;
        out_err_next    = out_err_reg;

        rd_en_a   = 1'b0;
        rd_en_b   = 1'b0;
        rd_addr_a = s_tdata[AW-1:0];
        rd_addr_b = s_tdata[IDX_W +: AW];
        wr_en     = 1'b0;
        wr_addr   = n_reg[AW-1:0];
        wr_data   = alu_res.wr_row;

        if (cfg_valid)
        begin
            node_count_next = cfg_data;
        end

        // drop the output beat once taken; a new load below overrides
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next  = s_tuser;
                    n_next     = s_tdata[IDX_W-1:0];
                    o_next     = s_tdata[2*IDX_W-1:IDX_W];
                    self_next  = s_tdata[2*IDX_W];
                    rd_en_a    = 1'b1;
                    rd_en_b    = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (kind_reg == rbm_pkg::KIND_APPLY)
                begin
                    walk_rd_next = '0;
                    pipe_v_next  = 1'b0;
                    cap_row_next = '0;
                    state_next   = ST_WALK;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_conn_next  = alu_res.connected;
                    out_row_next   = alu_res.row;
                    out_err_next   = alu_res.err;
                    if (alu_res.wr_en)
                    begin
                        wr_en                          = 1'b1;
                        row_valid_next[n_reg[AW-1:0]]  = 1'b1;
                    end
                    if (alu_res.fuse)
                    begin
                        union_next = union_reg | row_n;
                        mask_next  = mask_reg | (ROW_W'(1) << n_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                // update stage: row read last cycle
                if (pipe_v_reg)
                begin
                    if ((row_p & mask_reg) != '0)
                    begin
                        wr_en                                = 1'b1;
                        wr_addr                              = pipe_idx_reg[AW-1:0];
                        wr_data                              = row_p_new;
                        row_valid_next[pipe_idx_reg[AW-1:0]] = 1'b1;
                    end
                    if (pipe_idx_reg == n_reg)
                    begin
                        cap_row_next = row_p_new;
                    end
                end
                // read stage: advance through rows 0 to count-1
                if (walk_rd_reg < cnt)
                begin
                    rd_en_a       = 1'b1;
                    rd_addr_a     = walk_rd_reg[AW-1:0];
                    pipe_idx_next = walk_rd_reg[IDX_W-1:0];
                    pipe_v_next   = 1'b1;
                    walk_rd_next  = walk_rd_reg + CNT_W'(1);
                end
                else
                begin
                    pipe_v_next = 1'b0;
                    if (!pipe_v_reg)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_conn_next  = 1'b0;
                    out_row_next   = n_ok ? cap_row_reg : '0;
                    out_err_next   = !n_ok;
                    union_next     = '0;
                    mask_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= CNT_W'(64);
            row_valid_reg  <= '0;
            union_reg      <= '0;
            mask_reg       <= '0;
            walk_rd_reg    <= '0;
            pipe_v_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            row_valid_reg  <= row_valid_next;
            union_reg      <= union_next;
            mask_reg       <= mask_next;
            walk_rd_reg    <= walk_rd_next;
            pipe_v_reg     <= pipe_v_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        n_reg        <= n_next;
        o_reg        <= o_next;
        self_reg     <= self_next;
        pipe_idx_reg <= pipe_idx_next;
        cap_row_reg  <= cap_row_next;
        out_conn_reg <= out_conn_next;
        out_row_reg  <= out_row_next;
        out_err_reg  <= out_err_next;
    end

endmodule

FILE: dv/tb_reachability_bitmap_matrix.sv
// Testbench for the reachability bitmap matrix: directed and random graph traffic.
`timescale 1ns / 100ps

module tb_reachability_bitmap_matrix;

    localparam int NODES       = 64;
    localparam int CYCLE_LIMIT = 400000;

    // One result beat, fields in the order they are compared.
    typedef struct packed {
        logic                      connected;
        logic [rbm_pkg::ROW_W-1:0] row;
        logic                      err;
    } row_result_t;

    // Row predictor plus the queue of results still owed by the block.
    class reach_scoreboard;
        logic [rbm_pkg::ROW_W-1:0] rows [NODES];
        logic [rbm_pkg::ROW_W-1:0] fuse_union;
        logic [rbm_pkg::ROW_W-1:0] fuse_mask;
        int unsigned               node_limit;
        row_result_t               owed_q [$];
        int unsigned               mismatches;

        function new();
            foreach (rows[i])
                rows[i] = '0;
            fuse_union = '0;
            fuse_mask  = '0;
            node_limit = NODES;
            mismatches = 0;
        endfunction

        // Saturate the register value to the number of physical rows.
        function void set_count(logic [rbm_pkg::CNT_W-1:0] value);
            node_limit = (value > NODES) ? NODES : value;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted input beat to the predicted rows and queue its result.
        function void note_item(rbm_pkg::kind_t kind, logic [rbm_pkg::IDX_W-1:0] n,
                                logic [rbm_pkg::IDX_W-1:0] o, logic self_loop);
            row_result_t r;
            logic        n_ok;
            logic        o_ok;
            r    = '0;
            n_ok = (n < node_limit);
            o_ok = (o < node_limit);
            case (kind)
                rbm_pkg::KIND_BEGIN:
                    if (!n_ok)
                        r.err = 1'b1;
                    else
                    begin
                        if (!self_loop)
                            rows[n] = '0;
                        rows[n][n] = 1'b1;
                        r.row = rows[n];
                    end
                rbm_pkg::KIND_ADD:
                    if (!n_ok || !o_ok)
                        r.err = 1'b1;
                    else
                    begin
                        // a self edge leaves the row alone
                        if (o != n)
                            rows[n] |= rows[o];
                        r.row = rows[n];
                    end
                rbm_pkg::KIND_QUERY:
                    if (!n_ok || !o_ok)
                        r.err = 1'b1;
                    else
                    begin
                        r.row       = rows[n];
                        r.connected = rows[n][o];
                    end
                rbm_pkg::KIND_MEMBER:
                    if (!n_ok)
                        r.err = 1'b1;
                    else
                    begin
                        fuse_union |= rows[n];
                        fuse_mask[n] = 1'b1;
                        r.row = rows[n];
                    end
                rbm_pkg::KIND_APPLY:
                begin
                    // the walk and the clear happen even when the reported index is bad
                    for (int i = 0; i < node_limit; i++)
                        if ((rows[i] & fuse_mask) != '0)
                            rows[i] |= fuse_union;
                    fuse_union = '0;
                    fuse_mask  = '0;
                    if (n_ok)
                        r.row = rows[n];
                    else
                        r.err = 1'b1;
                end
                default: ;
            endcase
            owed_q.push_back(r);
        endfunction

        function void flag(string field, logic [rbm_pkg::ROW_W-1:0] want_v,
                           logic [rbm_pkg::ROW_W-1:0] got_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want_v, got_v);
        endfunction

        // Compare one output beat against the oldest owed result.
        function void check_beat(row_result_t got);
            row_result_t want;
            if (owed_q.size() == 0)
            begin
                flag("unexpected beat row_bits", '0, got.row);
                return;
            end
            want = owed_q.pop_front();
            if (got.connected !== want.connected)
                flag("connected", want.connected, got.connected);
            if (got.row !== want.row)
                flag("row_bits", want.row, got.row);
            if (got.err !== want.err)
                flag("index_error", want.err, got.err);
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [rbm_pkg::CNT_W-1:0]      cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rbm_pkg::IN_DATA_W-1:0]  s_tdata;    // [5:0] node_index, [11:6] other_index,
                                                // [12] self_loop
    logic [rbm_pkg::KIND_W-1:0]     s_tuser;    // [2:0] kind
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rbm_pkg::OUT_DATA_W-1:0] m_tdata;    // [0] connected, [64:1] row_bits
    logic                           m_tuser;    // [0] index_error

    reach_scoreboard sb = new();

    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;
    int          tx_idle_pct = 0;      // chance in percent that the sender skips a cycle
    int          rx_idle_pct = 0;      // chance in percent that the receiver stalls a cycle

    reachability_bitmap_matrix #(
        .MAX_NODES (NODES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Stall the output side at random; the rate follows the current idling mode.
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Check every output beat at the edge where it is taken.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(row_result_t'({m_tdata[0], m_tdata[rbm_pkg::ROW_W:1], m_tuser}));

    // Abort a run that hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Send one input beat. Enter and leave at a falling edge; s_tvalid stays high on return
    // so back-to-back beats do not drop it.
    task automatic send_item(rbm_pkg::kind_t kind, logic [rbm_pkg::IDX_W-1:0] n,
                             logic [rbm_pkg::IDX_W-1:0] o, logic self_loop);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {{(rbm_pkg::IN_DATA_W - 2*rbm_pkg::IDX_W - 1){1'b0}}, self_loop, o, n};
        s_tuser  <= kind;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(kind, n, o, self_loop);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the input low until every owed result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Write node_count once the block is idle; the gap covers the tail of a fusion walk.
    task automatic write_node_count(logic [rbm_pkg::CNT_W-1:0] value);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_count(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly an index inside the active range, now and then any index at all.
    function automatic logic [rbm_pkg::IDX_W-1:0] pick_node(int active);
        if (active == 0 || $urandom_range(19) == 0)
            return rbm_pkg::IDX_W'($urandom_range(NODES - 1));
        return rbm_pkg::IDX_W'($urandom_range(active - 1));
    endfunction

    // Random traffic under one node_count: mostly graphs built in topological order,
    // with queries and fusion groups on top, plus some raw noise.
    task automatic run_phase(logic [rbm_pkg::CNT_W-1:0] count, int n_items, int tx_pct,
                             int rx_pct);
        int                        active;
        int                        next_node;
        int                        target;
        int                        halfway;
        bit                        paused;
        int                        pick;
        logic [rbm_pkg::IDX_W-1:0] k;
        logic [rbm_pkg::IDX_W-1:0] o;
        active    = (count > NODES) ? NODES : count;
        next_node = 0;
        paused    = 0;
        write_node_count(count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target  = items_sent + n_items;
        halfway = items_sent + n_items / 2;
        while (items_sent < target)
        begin
            // hold off the sender once mid-phase until the output side has caught up
            if (!paused && items_sent >= halfway)
            begin
                drain_results();
                paused = 1;
            end
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                // define the next node, then wire in a few predecessors
                k = (active == 0) ? pick_node(active)
                                  : rbm_pkg::IDX_W'(next_node % active);
                next_node++;
                send_item(rbm_pkg::KIND_BEGIN, k, pick_node(active), $urandom_range(9) == 0);
                repeat ($urandom_range(3))
                begin
                    if (k > 0 && k < active && $urandom_range(9) < 8)
                        o = rbm_pkg::IDX_W'($urandom_range(k - 1));
                    else
                        o = pick_node(active);
                    send_item(rbm_pkg::KIND_ADD, k, o, 1'($urandom_range(1)));
                end
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(3, 1))
                    send_item(rbm_pkg::KIND_QUERY, pick_node(active), pick_node(active),
                              1'($urandom_range(1)));
            end
            else if (pick < 87)
            begin
                repeat ($urandom_range(3, 1))
                    send_item(rbm_pkg::KIND_MEMBER, pick_node(active), pick_node(active),
                              1'($urandom_range(1)));
                send_item(rbm_pkg::KIND_APPLY, pick_node(active), pick_node(active),
                          1'($urandom_range(1)));
            end
            else
            begin
                send_item(rbm_pkg::kind_t'($urandom_range(2**rbm_pkg::KIND_W - 1)),
                          rbm_pkg::IDX_W'($urandom_range(NODES - 1)),
                          rbm_pkg::IDX_W'($urandom_range(NODES - 1)),
                          1'($urandom_range(1)));
            end
        end
        drain_results();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset node count: a small chain, self edges, self loops,
        // both query answers, a fusion group and every unused kind code.
        send_item(rbm_pkg::KIND_BEGIN, 0, 0, 1'b0);
        send_item(rbm_pkg::KIND_BEGIN, 1, 0, 1'b0);
        send_item(rbm_pkg::KIND_ADD, 1, 0, 1'b0);
        send_item(rbm_pkg::KIND_ADD, 1, 1, 1'b1);
        send_item(rbm_pkg::KIND_BEGIN, 2, 0, 1'b1);
        send_item(rbm_pkg::KIND_ADD, 2, 1, 1'b0);
        send_item(rbm_pkg::KIND_QUERY, 2, 0, 1'b0);
        send_item(rbm_pkg::KIND_QUERY, 0, 2, 1'b0);
        send_item(rbm_pkg::KIND_BEGIN, rbm_pkg::IDX_W'(NODES - 1), rbm_pkg::IDX_W'(NODES - 1),
                  1'b0);
        send_item(rbm_pkg::KIND_ADD, rbm_pkg::IDX_W'(NODES - 1), 2, 1'b0);
        send_item(rbm_pkg::KIND_QUERY, rbm_pkg::IDX_W'(NODES - 1), rbm_pkg::IDX_W'(NODES - 1),
                  1'b1);
        send_item(rbm_pkg::KIND_MEMBER, 1, 0, 1'b0);
        send_item(rbm_pkg::KIND_MEMBER, rbm_pkg::IDX_W'(NODES - 1), 0, 1'b0);
        send_item(rbm_pkg::KIND_APPLY, 2, 0, 1'b0);
        send_item(rbm_pkg::KIND_QUERY, 2, rbm_pkg::IDX_W'(NODES - 1), 1'b0);
        send_item(rbm_pkg::KIND_BEGIN, 2, 0, 1'b1);
        send_item(rbm_pkg::KIND_BEGIN, 1, 0, 1'b0);
        send_item(rbm_pkg::KIND_APPLY, 0, rbm_pkg::IDX_W'(NODES - 1), 1'b1);
        for (int c = rbm_pkg::KIND_APPLY + 1; c < 2**rbm_pkg::KIND_W; c++)
            send_item(rbm_pkg::kind_t'(c), rbm_pkg::IDX_W'(NODES - 1),
                      rbm_pkg::IDX_W'(NODES - 1), 1'b1);

        // Shrink the node count and hit every out-of-range path, including a walk
        // whose reported index is bad.
        write_node_count(6);
        send_item(rbm_pkg::KIND_BEGIN, 6, 0, 1'b0);
        send_item(rbm_pkg::KIND_ADD, 2, 9, 1'b0);
        send_item(rbm_pkg::KIND_ADD, 9, 2, 1'b0);
        send_item(rbm_pkg::KIND_QUERY, 3, rbm_pkg::IDX_W'(NODES - 1), 1'b0);
        send_item(rbm_pkg::KIND_MEMBER, 7, 0, 1'b0);
        send_item(rbm_pkg::KIND_MEMBER, 2, 0, 1'b0);
        send_item(rbm_pkg::KIND_APPLY, 10, 0, 1'b0);
        send_item(rbm_pkg::KIND_QUERY, 2, 0, 1'b0);

        // Sender sparse idling, receiver heavy stalls.
        run_phase(rbm_pkg::CNT_W'(2**rbm_pkg::CNT_W - 1), 400, 22, 76);
        run_phase(1, 60, 22, 76);
        // Roles swapped.
        run_phase(0, 40, 76, 22);
        run_phase(rbm_pkg::CNT_W'(NODES), 400, 76, 22);
        // Full rate on both sides.
        run_phase(13, 300, 0, 0);
        run_phase(37, 200, 0, 0);

        drain_results();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: reachability_bitmap_matrix.f
src/rbm_pkg.sv
src/rbm_ram.sv
src/rbm_row_alu.sv
src/reachability_bitmap_matrix.sv
dv/tb_reachability_bitmap_matrix.sv
